FILE: hw/rtl/rhmd_pkg.sv
// Shared types, constants and functions for the rotating header message deframer.
`timescale 1ns / 1ps

package rhmd_pkg;

  localparam logic [7:0] LEAD_PING = 8'h50;
  localparam logic [7:0] LEAD_PONG = 8'h52;
  localparam logic [7:0] LEAD_MSG = 8'h4B;
  localparam logic [31:0] SEED_RESET = 32'h0000_0051;
  localparam int unsigned RotModulus = 3;
  localparam logic [1:0] ROT_MOD_RESET = 2'(SEED_RESET % RotModulus);
  localparam logic [1:0] HEADER_LAST_POS = 2'd3;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_HEADER,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  typedef enum logic [2:0] {
    EV_PING = 3'd0,
    EV_PONG = 3'd1,
    EV_START = 3'd2,
    EV_DATA = 3'd3,
    EV_BAD = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    ROLE_ZERO,
    ROLE_TYPE,
    ROLE_HI,
    ROLE_LO
  } role_t;

  typedef struct packed {
    logic valid;
    event_kind_t kind;
    logic [7:0] type_byte;
    logic [15:0] msg_length;
    logic [7:0] payload;
    logic last;
  } frame_result_t;

  typedef struct packed {
    logic load;
    logic [31:0] mix;
  } rot_update_t;

  // Picks what a header byte holds from the rotation residue and its position.
  function automatic role_t header_role(input logic [1:0] rot_mod, input logic [1:0] pos);
    role_t role;
    role = ROLE_ZERO;
    case (rot_mod)
      2'd0: begin
        case (pos)
          2'd0: role = ROLE_TYPE;
          2'd1: role = ROLE_ZERO;
          2'd2: role = ROLE_HI;
          default: role = ROLE_LO;
        endcase
      end
      2'd1: begin
        case (pos)
          2'd0: role = ROLE_ZERO;
          2'd1: role = ROLE_HI;
          2'd2: role = ROLE_TYPE;
          default: role = ROLE_LO;
        endcase
      end
      2'd2: begin
        case (pos)
          2'd0: role = ROLE_ZERO;
          2'd1: role = ROLE_LO;
          2'd2: role = ROLE_HI;
          default: role = ROLE_TYPE;
        endcase
      end
      default: role = ROLE_ZERO;
    endcase
    return role;
  endfunction

  // Residue modulo three, found by folding since every power of four is one modulo three.
  function automatic logic [1:0] mod3_32(input logic [31:0] x);
    logic [16:0] s17;
    logic [9:0] s10;
    logic [6:0] s7;
    logic [5:0] s6;
    logic [4:0] s5;
    logic [3:0] s4;
    logic [2:0] s3;
    logic [1:0] r;
    s17 = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    s10 = {1'b0, s17[16:8]} + {2'b0, s17[7:0]};
    s7 = {1'b0, s10[9:4]} + {3'b0, s10[3:0]};
    s6 = {1'b0, s7[6:2]} + {4'b0, s7[1:0]};
    s5 = {1'b0, s6[5:2]} + {3'b0, s6[1:0]};
    s4 = {1'b0, s5[4:2]} + {2'b0, s5[1:0]};
    s3 = {1'b0, s4[3:2]} + {1'b0, s4[1:0]};
    case (s3)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/rhmd_channels.sv
// Valid/ready channel interfaces for the input byte stream and the result words.
`timescale 1ns / 1ps

interface rhmd_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rhmd_out_if;
  logic valid;
  logic ready;
  logic [2:0] event_kind;
  logic [7:0] message_type;
  logic [15:0] message_length;
  logic [7:0] payload_byte;
  logic last_of_message;

  modport source (
    output valid, output event_kind, output message_type, output message_length,
    output payload_byte, output last_of_message, input ready
  );
  modport sink (
    input valid, input event_kind, input message_type, input message_length,
    input payload_byte, input last_of_message, output ready
  );
endinterface

FILE: hw/rtl/rhmd_rotation.sv
// Running header rotation word and its registered residue modulo three.
`timescale 1ns / 1ps

module rhmd_rotation import rhmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  rot_update_t rot_upd,
  output logic [1:0]  rot_mod
);

  logic [31:0] rotation_word, rotation_word_next;

  always_comb begin
    rotation_word_next = rotation_word;
    if (cfg_wr_en) begin
      rotation_word_next = cfg_wr_data;
    end else if (rot_upd.load) begin
      rotation_word_next = rotation_word ^ rot_upd.mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_word <= SEED_RESET;
      rot_mod <= ROT_MOD_RESET;
    end else begin
      rotation_word <= rotation_word_next;
      rot_mod <= mod3_32(rotation_word_next);
    end
  end

endmodule

FILE: hw/rtl/rhmd_deframer.sv
// Frame state machine: lead byte decode, rotated header capture and payload count.
`timescale 1ns / 1ps

module rhmd_deframer import rhmd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic [1:0]    rot_mod,
  output frame_result_t result,
  output rot_update_t   rot_upd
);

  phase_t      phase, phase_next;
  logic [1:0]  header_position, header_position_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  role_t       role;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_length;
  logic [16:0] hdr_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      header_position <= 2'd0;
      held_type <= 8'd0;
      held_length <= 16'd0;
      bytes_left <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      header_position <= header_position_next;
      held_type <= held_type_next;
      held_length <= held_length_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_comb begin
    role = header_role(rot_mod, header_position);
    hdr_type = held_type;
    hdr_length = held_length;
    case (role)
      ROLE_TYPE: hdr_type = in_byte;
      ROLE_HI: hdr_length = {in_byte, held_length[7:0]};
      ROLE_LO: hdr_length = {held_length[15:8], in_byte};
      default: hdr_type = held_type;
    endcase
    hdr_sum = {1'b0, hdr_length} + {9'd0, hdr_type};

    phase_next = phase;
    header_position_next = header_position;
    held_type_next = held_type;
    held_length_next = held_length;
    bytes_left_next = bytes_left;
    result.valid = 1'b0;
    result.kind = EV_PING;
    result.type_byte = 8'd0;
    result.msg_length = 16'd0;
    result.payload = 8'd0;
    result.last = 1'b0;
    rot_upd.load = 1'b0;
    rot_upd.mix = ~{15'd0, hdr_sum};

    case (phase)
      PH_LEAD: begin
        if (in_byte == LEAD_PING) begin
          result.valid = 1'b1;
          result.kind = EV_PING;
        end else if (in_byte == LEAD_PONG) begin
          result.valid = 1'b1;
          result.kind = EV_PONG;
        end else if (in_byte == LEAD_MSG) begin
          phase_next = PH_HEADER;
          header_position_next = 2'd0;
          held_type_next = 8'd0;
          held_length_next = 16'd0;
        end else begin
          phase_next = PH_HALTED;
          result.valid = 1'b1;
          result.kind = EV_BAD;
        end
      end
      PH_HEADER: begin
        held_type_next = hdr_type;
        held_length_next = hdr_length;
        if (header_position != HEADER_LAST_POS) begin
          header_position_next = header_position + 2'd1;
        end else begin
          header_position_next = 2'd0;
          rot_upd.load = accept;
          bytes_left_next = hdr_length;
          phase_next = (hdr_length == 16'd0) ? PH_LEAD : PH_PAYLOAD;
          result.valid = 1'b1;
          result.kind = EV_START;
          result.type_byte = hdr_type;
          result.msg_length = hdr_length;
          result.last = (hdr_length == 16'd0);
        end
      end
      PH_PAYLOAD: begin
        result.valid = 1'b1;
        result.kind = EV_DATA;
        result.type_byte = held_type;
        result.msg_length = held_length;
        result.payload = in_byte;
        result.last = (bytes_left <= 16'd1);
        if (bytes_left <= 16'd1) begin
          bytes_left_next = 16'd0;
          phase_next = PH_LEAD;
        end else begin
          bytes_left_next = bytes_left - 16'd1;
        end
      end
      default: begin
        phase_next = PH_HALTED;
      end
    endcase
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALTED |=> phase == PH_HALTED)
    else $error("deframer left the halted state without reset");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != 16'd0)
    else $error("payload phase entered with no bytes left");

  a_header_pos_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> header_position == 2'd0)
    else $error("header position nonzero outside the header");

  a_rot_update: assert property (@(posedge clk) disable iff (rst)
    rot_upd.load |-> accept && phase == PH_HEADER && header_position == HEADER_LAST_POS
      && result.valid && result.kind == EV_START)
    else $error("rotation word updated outside the end of a header");

endmodule

FILE: hw/rtl/rotating_header_message_deframer.sv
// Top level of the rotating header message deframer with its output register.
// Output: a result word is registered and appears on the output in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the input is taken whenever the output register is
// empty or being emptied in the same cycle.
// Reset: synchronous, active high; clears the frame state, empties the output register and
// loads the rotation word with its reset seed.
`timescale 1ns / 1ps

module rotating_header_message_deframer import rhmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  rhmd_in_if.sink     stream,
  rhmd_out_if.source  events
);

  logic          accept;
  logic [1:0]    rot_mod;
  frame_result_t result;
  rot_update_t   rot_upd;
  logic          out_valid;
  frame_result_t out_word;

  assign stream.ready = !out_valid || events.ready;
  assign accept = stream.valid && stream.ready;

  rhmd_rotation u_rotation (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rot_upd     (rot_upd),
    .rot_mod     (rot_mod)
  );

  rhmd_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (stream.in_byte),
    .rot_mod (rot_mod),
    .result  (result),
    .rot_upd (rot_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stream.ready) begin
      out_valid <= accept && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      out_word <= result;
    end
  end

  assign events.valid = out_valid;
  assign events.event_kind = out_word.kind;
  assign events.message_type = out_word.type_byte;
  assign events.message_length = out_word.msg_length;
  assign events.payload_byte = out_word.payload;
  assign events.last_of_message = out_word.last;

endmodule
